// File: hw/rtl/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants for the cave smoothing block: default grid limits,
// register indexes, request codes and the wall threshold.
// ----------------------------------------------------------------------------
package cas_pkg;

    // Default storage limits
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    // Configuration register file
    localparam int             CFG_W        = 7;
    localparam logic           CFG_WIDTH    = 1'b0;
    localparam logic           CFG_HEIGHT   = 1'b1;
    localparam logic [CFG_W-1:0] GRID_DIM_RST = 7'd64;

    // Request kinds
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SMOOTH = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Neighbour count at which a cell keeps its value
    localparam logic [3:0] WALL_PIVOT = 4'd4;

endpackage

// File: hw/rtl/cas_ram.sv
// ----------------------------------------------------------------------------
// cas_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cave_automaton_smoothing_top.sv
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_top
// One-bit cave grid with cell load, cell read and in-place 4-5 rule
// smoothing sweeps. Each RAM word holds one column of the grid.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Payload
//  request   in         i_req_valid / o_req_ready     i_req_type, i_col, i_row, i_cell_in
//  ack       out        o_ack_valid / i_ack_ready     o_ack_kind, o_cell_out
//  config    in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
//  Load and read pass through a RAM wait state and then the response state
//  before the ack register; an unknown kind, a cell beyond storage or an
//  empty sweep goes straight to the response state. A smoothing sweep
//  updates the three-column window cell by cell, plus a write-back and a
//  column fetch through the single RAM read port at every column step.
//  After reset a clearing pass zeroes all MAX_COLS columns of the RAM, one
//  column a cycle, while no request is taken. One request is in work at a
//  time; the next one is taken while an ack still waits in the output register.
// ----------------------------------------------------------------------------
module cave_automaton_smoothing_top #(
    parameter int MAX_COLS = cas_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = cas_pkg::MAX_ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [cas_pkg::CFG_W-1:0] i_cfg_data,
    // Request channel
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  logic [1:0]               i_req_type,
    input  logic [5:0]               i_col,
    input  logic [5:0]               i_row,
    input  logic                     i_cell_in,
    // Ack channel
    output logic                     o_ack_valid,
    input  logic                     i_ack_ready,
    output logic [1:0]               o_ack_kind,
    output logic                     o_cell_out
);

    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int ROW_IW = $clog2(MAX_ROWS);
    localparam int DW     = cas_pkg::CFG_W;

    localparam logic [DW-1:0]     COLS_CAP = (MAX_COLS > 127) ? 7'd127 : DW'(MAX_COLS);
    localparam logic [DW-1:0]     ROWS_CAP = (MAX_ROWS > 127) ? 7'd127 : DW'(MAX_ROWS);
    localparam logic [COL_AW-1:0] CLR_LAST = COL_AW'(MAX_COLS - 1);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_LD_WAIT  = 10'b00_0000_0100,
        S_RD_WAIT  = 10'b00_0000_1000,
        S_SM_PRE0  = 10'b00_0001_0000,
        S_SM_PRE1  = 10'b00_0010_0000,
        S_SM_ROW   = 10'b00_0100_0000,
        S_SM_WB    = 10'b00_1000_0000,
        S_SM_SHIFT = 10'b01_0000_0000,
        S_RESP     = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [DW-1:0]       r_grid_width, r_grid_height;
    logic [COL_AW-1:0]   r_clr, n_clr;
    logic [DW-1:0]       r_c, n_c, r_r, n_r;
    logic [1:0]          r_kind;
    logic [5:0]          r_col, r_row;
    logic                r_cell, r_inside;
    logic [MAX_ROWS-1:0] r_lcol, n_lcol, r_ccol, n_ccol, r_rcol, n_rcol;
    logic                r_res_cell, n_res_cell;
    logic                r_ack_valid, n_ack_valid;
    logic [1:0]          r_ack_kind, n_ack_kind;
    logic                r_ack_cell, n_ack_cell;

    logic                req_acc, inside_in, sweep_empty, ack_load;
    logic [DW-1:0]       eff_w, eff_h;
    logic                last_row, last_col;

    logic                ram_we;
    logic [COL_AW-1:0]   ram_waddr, ram_raddr;
    logic [MAX_ROWS-1:0] ram_wdata, ram_rdata, ld_word;

    logic [ROW_IW-1:0]   ri, rm1, rp1;
    logic                up_ok, nb_ul, nb_uc, nb_ur, new_cell;
    logic [3:0]          nb_cnt;

    // Effective grid size, saturated to the storage limits
    assign eff_w       = (r_grid_width  > COLS_CAP) ? COLS_CAP : r_grid_width;
    assign eff_h       = (r_grid_height > ROWS_CAP) ? ROWS_CAP : r_grid_height;
    assign sweep_empty = (eff_w < 7'd2) || (eff_h < 7'd2);
    assign last_row    = (r_r == DW'(eff_h - 7'd2));
    assign last_col    = (r_c == DW'(eff_w - 7'd2));

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign inside_in   = (32'(i_col) < 32'(MAX_COLS)) && (32'(i_row) < 32'(MAX_ROWS));
    assign ack_load    = (r_state == S_RESP) && (!r_ack_valid || i_ack_ready);

    // Neighbour window around row r of the centre column
    assign up_ok  = (r_r != 7'd0);
    assign ri     = ROW_IW'(r_r);
    assign rp1    = ROW_IW'(r_r + 7'd1);
    assign rm1    = up_ok ? ROW_IW'(r_r - 7'd1) : '0;
    assign nb_ul  = up_ok ? r_lcol[rm1] : 1'b1;
    assign nb_uc  = up_ok ? r_ccol[rm1] : 1'b1;
    assign nb_ur  = up_ok ? r_rcol[rm1] : 1'b1;
    assign nb_cnt = 4'(nb_ul) + 4'(r_lcol[ri]) + 4'(r_lcol[rp1])
                  + 4'(nb_uc) + 4'(r_ccol[rp1])
                  + 4'(nb_ur) + 4'(r_rcol[ri]) + 4'(r_rcol[rp1]);

    always_comb begin
        if (nb_cnt > cas_pkg::WALL_PIVOT) begin
            new_cell = 1'b1;
        end else if (nb_cnt < cas_pkg::WALL_PIVOT) begin
            new_cell = 1'b0;
        end else begin
            new_cell = r_ccol[ri];
        end
    end

    // Column word with the loaded cell patched in
    always_comb begin
        ld_word                     = ram_rdata;
        ld_word[ROW_IW'(r_row)]     = r_cell;
    end

    // Sequencer and RAM port control
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_c        = r_c;
        n_r        = r_r;
        n_lcol     = r_lcol;
        n_ccol     = r_ccol;
        n_rcol     = r_rcol;
        n_res_cell = r_res_cell;
        ram_we     = 1'b0;
        ram_waddr  = COL_AW'(r_c);
        ram_wdata  = r_ccol;
        ram_raddr  = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = (i_req_type == cas_pkg::REQ_SMOOTH) ? '0 : COL_AW'(i_col);
                if (req_acc) begin
                    n_res_cell = 1'b0;
                    unique case (i_req_type)
                        cas_pkg::REQ_LOAD:   n_state = inside_in ? S_LD_WAIT : S_RESP;
                        cas_pkg::REQ_READ:   n_state = inside_in ? S_RD_WAIT : S_RESP;
                        cas_pkg::REQ_SMOOTH: n_state = sweep_empty ? S_RESP : S_SM_PRE0;
                        default:             n_state = S_RESP;
                    endcase
                end
            end
            S_LD_WAIT: begin
                ram_we    = 1'b1;
                ram_waddr = COL_AW'(r_col);
                ram_wdata = ld_word;
                n_state   = S_RESP;
            end
            S_RD_WAIT: begin
                n_res_cell = ram_rdata[ROW_IW'(r_row)];
                n_state    = S_RESP;
            end
            S_SM_PRE0: begin
                // Column 0 arrives; left of it is all wall; fetch column 1
                n_ccol    = ram_rdata;
                n_lcol    = '1;
                ram_raddr = COL_AW'(1);
                n_state   = S_SM_PRE1;
            end
            S_SM_PRE1: begin
                n_rcol  = ram_rdata;
                n_c     = '0;
                n_r     = '0;
                n_state = S_SM_ROW;
            end
            S_SM_ROW: begin
                // Update one cell in place; later rows see the new value
                n_ccol[ri] = new_cell;
                n_r        = r_r + 7'd1;
                if (last_row) begin
                    n_state = S_SM_WB;
                end
            end
            S_SM_WB: begin
                // Write the finished column back, fetch the next right column
                ram_we    = 1'b1;
                ram_waddr = COL_AW'(r_c);
                ram_wdata = r_ccol;
                ram_raddr = COL_AW'(r_c + 7'd2);
                n_state   = last_col ? S_RESP : S_SM_SHIFT;
            end
            S_SM_SHIFT: begin
                n_lcol  = r_ccol;
                n_ccol  = r_rcol;
                n_rcol  = ram_rdata;
                n_c     = r_c + 7'd1;
                n_r     = '0;
                n_state = S_SM_ROW;
            end
            S_RESP: begin
                if (ack_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Ack register: load from the finished request, drop when taken
    always_comb begin
        n_ack_valid = r_ack_valid;
        n_ack_kind  = r_ack_kind;
        n_ack_cell  = r_ack_cell;
        if (ack_load) begin
            n_ack_valid = 1'b1;
            n_ack_kind  = r_kind;
            n_ack_cell  = r_res_cell;
        end else if (r_ack_valid && i_ack_ready) begin
            n_ack_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_c           <= '0;
            r_r           <= '0;
            r_ack_valid   <= 1'b0;
            r_grid_width  <= cas_pkg::GRID_DIM_RST;
            r_grid_height <= cas_pkg::GRID_DIM_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_c         <= n_c;
            r_r         <= n_r;
            r_ack_valid <= n_ack_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == cas_pkg::CFG_WIDTH) begin
                    r_grid_width <= i_cfg_data;
                end
                if (i_cfg_idx == cas_pkg::CFG_HEIGHT) begin
                    r_grid_height <= i_cfg_data;
                end
            end
        end
    end

    // Payload and window registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_kind   <= i_req_type;
            r_col    <= i_col;
            r_row    <= i_row;
            r_cell   <= i_cell_in;
            r_inside <= inside_in;
        end
        r_lcol     <= n_lcol;
        r_ccol     <= n_ccol;
        r_rcol     <= n_rcol;
        r_res_cell <= n_res_cell;
        r_ack_kind <= n_ack_kind;
        r_ack_cell <= n_ack_cell;
    end

    cas_ram #(
        .WIDTH (MAX_ROWS),
        .DEPTH (MAX_COLS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ack_valid = r_ack_valid;
    assign o_ack_kind  = r_ack_kind;
    assign o_cell_out  = r_ack_cell;

    // One request in work at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !o_req_ready)
        else $error("request taken while another is in work");

    // No ack while the RAM is being cleared
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ack_valid)
        else $error("ack during clearing pass");

    // Sweep row pointer stays inside the smoothed rows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SM_ROW) |-> (r_r <= DW'(eff_h - 7'd2)))
        else $error("sweep row beyond grid");

    // A column step only happens before the last smoothed column
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SM_SHIFT) |-> (r_c < DW'(eff_w - 7'd2)))
        else $error("sweep column beyond grid");

    // Loads and reads touch the RAM only for cells inside storage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LD_WAIT) || (r_state == S_RD_WAIT)) |-> r_inside)
        else $error("cell access outside storage");

endmodule

// File: test/tb_cave_automaton_smoothing_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cave_automaton_smoothing_top
// Self-checking bench for the cave smoothing block. Drives load, read,
// smoothing and unknown requests over a range of grid sizes. A scoreboard
// keeps its own copy of the wall grid, predicts every acknowledgement and
// checks each one in order. Both channels idle at random, and one long
// acknowledgement hold-off forces the request channel to stall.
// ----------------------------------------------------------------------------
module tb_cave_automaton_smoothing_top;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         N_COLS      = cas_pkg::MAX_COLS_DEF;
    localparam int         N_ROWS      = cas_pkg::MAX_ROWS_DEF;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         HOLD_CYCLES = 150;
    localparam int         PHASE_ITEMS = 10;
    localparam int         N_PHASES    = 12;

    typedef struct {
        logic [1:0] kind;
        logic       cell_val;
    } t_ack;

    // Grid model and queue of acknowledgements still owed by the block
    class cave_grid_scoreboard;
        bit   cells [N_COLS][N_ROWS];
        int   cols_set;
        int   rows_set;
        t_ack acks_due [$];
        int   failures;

        function new();
            cols_set = cas_pkg::GRID_DIM_RST;
            rows_set = cas_pkg::GRID_DIM_RST;
            failures = 0;
        endfunction

        function int used_cols();
            return (cols_set > N_COLS) ? N_COLS : cols_set;
        endfunction

        function int used_rows();
            return (rows_set > N_ROWS) ? N_ROWS : rows_set;
        endfunction

        function void set_dim(logic idx, logic [cas_pkg::CFG_W-1:0] value);
            if (idx == cas_pkg::CFG_WIDTH)
                cols_set = value;
            else
                rows_set = value;
        endfunction

        // Positions outside the grid in use count as walls
        function int count_walls(int c, int r, int w, int h);
            int n;
            n = 0;
            for (int dc = -1; dc <= 1; dc++) begin
                for (int dr = -1; dr <= 1; dr++) begin
                    if (dc == 0 && dr == 0)
                        continue;
                    if (c + dc < 0 || c + dc >= w || r + dr < 0 || r + dr >= h)
                        n++;
                    else
                        n += cells[c + dc][r + dr];
                end
            end
            return n;
        endfunction

        // In-place sweep, column-major, last column and last row skipped
        function void smooth_grid();
            int w;
            int h;
            int n;
            w = used_cols();
            h = used_rows();
            for (int c = 0; c < w - 1; c++) begin
                for (int r = 0; r < h - 1; r++) begin
                    n = count_walls(c, r, w, h);
                    if (n > cas_pkg::WALL_PIVOT)
                        cells[c][r] = 1'b1;
                    else if (n < cas_pkg::WALL_PIVOT)
                        cells[c][r] = 1'b0;
                end
            end
        endfunction

        function void note_request(logic [1:0] kind, logic [5:0] col, logic [5:0] row,
                                   logic cell_in);
            t_ack due;
            due.kind     = kind;
            due.cell_val = 1'b0;
            case (kind)
                cas_pkg::REQ_LOAD:   cells[col][row] = cell_in;
                cas_pkg::REQ_SMOOTH: smooth_grid();
                cas_pkg::REQ_READ:   due.cell_val = cells[col][row];
                default:             ;
            endcase
            acks_due.push_back(due);
        endfunction

        function void check_ack(logic [1:0] kind, logic cell_val);
            t_ack due;
            if (acks_due.size() == 0) begin
                $error("unexpected transaction: ack_kind %0d cell_out %0d", kind, cell_val);
                failures++;
                return;
            end
            due = acks_due.pop_front();
            if (kind !== due.kind) begin
                $error("ack_kind mismatch: expected %0d, actual %0d", due.kind, kind);
                failures++;
            end
            if (cell_val !== due.cell_val) begin
                $error("cell_out mismatch: expected %0d, actual %0d", due.cell_val, cell_val);
                failures++;
            end
        endfunction

        function int pending();
            return acks_due.size();
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic                      cfg_idx   = cas_pkg::CFG_WIDTH;
    logic [cas_pkg::CFG_W-1:0] cfg_data  = '0;
    logic                      req_valid = 1'b0;
    logic                      req_ready;
    logic [1:0]                req_type  = cas_pkg::REQ_LOAD;
    logic [5:0]                req_col   = '0;
    logic [5:0]                req_row   = '0;
    logic                      req_cell  = 1'b0;
    logic                      ack_valid;
    logic                      ack_ready = 1'b0;
    logic [1:0]                ack_kind;
    logic                      ack_cell;

    cave_grid_scoreboard grid_sb;
    bit steady        = 1'b0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycles        = 0;

    cave_automaton_smoothing_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req_type  (req_type),
        .i_col       (req_col),
        .i_row       (req_row),
        .i_cell_in   (req_cell),
        .o_ack_valid (ack_valid),
        .i_ack_ready (ack_ready),
        .o_ack_kind  (ack_kind),
        .o_cell_out  (ack_cell)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_cave_automaton_smoothing_top failed");
            $finish;
        end
    end

    // Ack side: random back-pressure, plus a long hold-off when asked for
    always @(negedge clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ack_ready = 1'b0;
        end else begin
            ack_ready = steady || ($urandom_range(0, 99) >= 24);
        end
    end

    // Check every acknowledgement transaction
    always @(posedge clk) begin
        if (rst_n && ack_valid && ack_ready)
            grid_sb.check_ack(ack_kind, ack_cell);
    end

    // Offer one request and hold it until accepted; called at a falling edge
    task automatic send_request(input logic [1:0] kind, input logic [5:0] col,
                                input logic [5:0] row, input logic cell_in);
        if (!steady && $urandom_range(0, 99) < 24) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_type  = kind;
        req_col   = col;
        req_row   = row;
        req_cell  = cell_in;
        req_valid = 1'b1;
        do @(posedge clk); while (!req_ready);
        grid_sb.note_request(kind, col, row, cell_in);
        @(negedge clk);
    endtask

    // Drain all outstanding acknowledgements, then let the block settle
    task automatic drain_acks();
        req_valid = 1'b0;
        while (grid_sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_dim(input logic idx, input logic [cas_pkg::CFG_W-1:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(posedge clk);
        grid_sb.set_dim(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mostly inside (or just past) the grid in use, sometimes anywhere
    function automatic logic [5:0] pick_pos(int span);
        if (span > 0 && $urandom_range(0, 99) < 80)
            return 6'($urandom_range(0, (span < 64 ? span : 63)));
        return 6'($urandom_range(0, 63));
    endfunction

    initial begin
        int         dims_w [N_PHASES];
        int         dims_h [N_PHASES];
        int         pick;
        int         smooth_cap;
        int         smooths;
        logic [1:0] kind;

        dims_w = '{5, 3, 127, 0, 2, 8, 65, 3, 12, 64, 6, 1};
        dims_h = '{4, 3, 127, 7, 9, 2, 3, 100, 10, 64, 6, 1};
        grid_sb = new();

        // Hold reset, then release it at a falling edge
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: corners, every request kind, sweep at full size
        send_request(cas_pkg::REQ_READ,   6'd0,  6'd0,  1'b0);
        send_request(cas_pkg::REQ_LOAD,   6'd63, 6'd63, 1'b1);
        send_request(cas_pkg::REQ_READ,   6'd63, 6'd63, 1'b0);
        send_request(cas_pkg::REQ_LOAD,   6'd0,  6'd0,  1'b1);
        send_request(cas_pkg::REQ_LOAD,   6'd0,  6'd63, 1'b1);
        send_request(cas_pkg::REQ_LOAD,   6'd63, 6'd0,  1'b1);
        send_request(cas_pkg::REQ_READ,   6'd0,  6'd63, 1'b0);
        send_request(REQ_UNKNOWN,         6'd63, 6'd63, 1'b1);
        send_request(cas_pkg::REQ_READ,   6'd63, 6'd0,  1'b0);
        send_request(cas_pkg::REQ_LOAD,   6'd1,  6'd1,  1'b1);
        send_request(cas_pkg::REQ_LOAD,   6'd2,  6'd1,  1'b1);
        send_request(cas_pkg::REQ_LOAD,   6'd42, 6'd21, 1'b0);
        send_request(cas_pkg::REQ_SMOOTH, 6'd0,  6'd0,  1'b0);
        send_request(cas_pkg::REQ_READ,   6'd0,  6'd0,  1'b0);
        send_request(cas_pkg::REQ_READ,   6'd1,  6'd1,  1'b0);
        send_request(cas_pkg::REQ_READ,   6'd2,  6'd1,  1'b0);
        send_request(cas_pkg::REQ_READ,   6'd63, 6'd63, 1'b1);
        send_request(cas_pkg::REQ_READ,   6'd62, 6'd62, 1'b0);

        // Random phases, one grid size each
        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain_acks();
            write_dim(cas_pkg::CFG_WIDTH,  cas_pkg::CFG_W'(dims_w[phase]));
            write_dim(cas_pkg::CFG_HEIGHT, cas_pkg::CFG_W'(dims_h[phase]));
            steady = (phase == 2);
            // Stall the acks for a long stretch while requests keep coming
            if (phase == 0)
                hold_requests++;
            smooth_cap = (grid_sb.used_cols() * grid_sb.used_rows() > 256) ? 1 : 3;
            smooths    = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 48)
                    kind = cas_pkg::REQ_LOAD;
                else if (pick < 76)
                    kind = cas_pkg::REQ_READ;
                else if (pick < 95 && smooths < smooth_cap)
                    kind = cas_pkg::REQ_SMOOTH;
                else if (pick >= 95)
                    kind = REQ_UNKNOWN;
                else
                    kind = cas_pkg::REQ_READ;
                if (kind == cas_pkg::REQ_SMOOTH)
                    smooths++;
                send_request(kind, pick_pos(grid_sb.used_cols()),
                             pick_pos(grid_sb.used_rows()),
                             $urandom_range(0, 99) < 55);
            end
        end
        steady = 1'b0;

        // Wait for the last acks, then watch for stray ones
        drain_acks();
        repeat (24) @(negedge clk);
        if (grid_sb.failures == 0 && grid_sb.pending() == 0)
            $display("tb_cave_automaton_smoothing_top passed");
        else
            $display("tb_cave_automaton_smoothing_top failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cas_pkg.sv
hw/rtl/cas_ram.sv
hw/rtl/cave_automaton_smoothing_top.sv
test/tb_cave_automaton_smoothing_top.sv
